FILE: rtl/mip_ds_pkg.sv
// Package for the 2x2 mip level downsampler.
// Holds field widths, register indexes and size limits; depends on nothing.
package mip_ds_pkg;

	// Channel and pixel widths
	localparam int CH_W   = 8;
	localparam int PIX_W  = 4 * CH_W;
	localparam int PAIR_W = CH_W + 1;
	localparam int BLK_W  = CH_W + 2;

	// Pair store entry: four pair sums, then the pair's maximum alpha
	localparam int ENTRY_W = 4 * PAIR_W + CH_W;

	// Size registers
	localparam int DIM_W      = 13;
	localparam int ROW_W      = 12;
	localparam int HEIGHT_CAP = 4096;

	// APB side
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	typedef enum logic {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

FILE: rtl/mipmap_2x2_downsample.sv
// 2x2 box filter mip level downsampler, RGBA8 in and out.
// A block's last pixel passes the stage 1 registers, then the output register.
// Throughput: one source pixel per cycle while the output is not stalled.
// Reset (arst_n low): counters and output valid clear, size registers return to 2.
// The line store has one write and one read port and needs no clearing pass: each
// entry is written on an even row before the odd row reads it.
module mipmap_2x2_downsample import mip_ds_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	// source pixels
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [PIX_W-1:0]  s_tdata,  // red_in, green_in, blue_in, alpha_in
	// mip level pixels
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [PIX_W-1:0]  m_tdata,  // red_out, green_out, blue_out, alpha_out
	output logic              m_tlast,  // row_end
	output logic              m_tuser,  // image_end
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int EW    = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
	localparam int WCAP  = MAX_WIDTH - (MAX_WIDTH % 2);

	// Configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(2);
			height_q <= DIM_W'(2);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SRC_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SRC_WIDTH:  prdata = APB_DW'(width_q);
			REG_SRC_HEIGHT: prdata = APB_DW'(height_q);
			default:        prdata = '0;
		endcase
	end

	// Effective sizes: even, at least 2, capped
	logic [EW-1:0]    w_raw, w_eff;
	logic [DIM_W-1:0] h_raw, h_eff;

	always_comb begin
		w_raw = EW'(width_q) & ~EW'(1);
		if (w_raw < EW'(2))
			w_eff = EW'(2);
		else if (w_raw > EW'(WCAP))
			w_eff = EW'(WCAP);
		else
			w_eff = w_raw;
		h_raw = height_q & ~DIM_W'(1);
		if (h_raw < DIM_W'(2))
			h_eff = DIM_W'(2);
		else if (h_raw > DIM_W'(HEIGHT_CAP))
			h_eff = DIM_W'(HEIGHT_CAP);
		else
			h_eff = h_raw;
	end

	// Pipeline control
	logic s1_valid_q, out_valid_q;
	logic s1_move, accept;

	assign s1_move  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_move;
	assign accept   = s_tvalid && s_tready;

	// Position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             col_last, row_last, odd_col, odd_row;

	assign col_last = EW'(col_q) == (w_eff - EW'(1));
	assign row_last = DIM_W'(row_q) == (h_eff - DIM_W'(1));
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Even column pixel of the current pair
	logic [PIX_W-1:0] held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (accept && !odd_col)
			held_q <= s_tdata;
	end

	// Horizontal pair sums and pair maximum alpha
	logic [PAIR_W-1:0] pair_r, pair_g, pair_b, pair_a;
	logic [CH_W-1:0]   a_even, a_odd, pair_max;

	assign pair_r   = PAIR_W'(held_q[7:0])   + PAIR_W'(s_tdata[7:0]);
	assign pair_g   = PAIR_W'(held_q[15:8])  + PAIR_W'(s_tdata[15:8]);
	assign pair_b   = PAIR_W'(held_q[23:16]) + PAIR_W'(s_tdata[23:16]);
	assign pair_a   = PAIR_W'(held_q[31:24]) + PAIR_W'(s_tdata[31:24]);
	assign a_even   = held_q[31:24];
	assign a_odd    = s_tdata[31:24];
	assign pair_max = (a_even > a_odd) ? a_even : a_odd;

	// Line store: written on even rows, read back on odd rows
	logic [ENTRY_W-1:0] store_mem [DEPTH];
	logic [ENTRY_W-1:0] store_rd_s1;
	logic [IW-1:0]      store_idx;
	logic               store_wr, store_rd;

	assign store_idx = col_q[IW:1];
	assign store_wr  = accept && odd_col && !odd_row;
	assign store_rd  = accept && odd_col && odd_row;

	always_ff @(posedge clk) begin
		if (store_wr)
			store_mem[store_idx] <= {pair_max, pair_a, pair_b, pair_g, pair_r};
		if (store_rd)
			store_rd_s1 <= store_mem[store_idx];
	end

	// Stage 1: the lower pair of a block waits for the store read
	logic [PAIR_W-1:0] r_s1, g_s1, b_s1, a_s1;
	logic [CH_W-1:0]   max_s1;
	logic              row_end_s1, image_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (store_rd)
			s1_valid_q <= 1'b1;
		else if (s1_move)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (store_rd) begin
			r_s1         <= pair_r;
			g_s1         <= pair_g;
			b_s1         <= pair_b;
			a_s1         <= pair_a;
			max_s1       <= pair_max;
			row_end_s1   <= col_last;
			image_end_s1 <= col_last && row_last;
		end
	end

	// Block sums, averages and boosted alpha
	logic [BLK_W-1:0] blk_r, blk_g, blk_b, blk_a;
	logic [CH_W-1:0]  top_max, blk_max, avg_a;
	logic [CH_W:0]    alpha_sum;
	logic [PIX_W-1:0] result;

	always_comb begin
		blk_r     = BLK_W'(r_s1) + BLK_W'(store_rd_s1[PAIR_W-1:0]);
		blk_g     = BLK_W'(g_s1) + BLK_W'(store_rd_s1[2*PAIR_W-1:PAIR_W]);
		blk_b     = BLK_W'(b_s1) + BLK_W'(store_rd_s1[3*PAIR_W-1:2*PAIR_W]);
		blk_a     = BLK_W'(a_s1) + BLK_W'(store_rd_s1[4*PAIR_W-1:3*PAIR_W]);
		top_max   = store_rd_s1[ENTRY_W-1:4*PAIR_W];
		blk_max   = (top_max > max_s1) ? top_max : max_s1;
		avg_a     = blk_a[BLK_W-1:2];
		alpha_sum = (CH_W+1)'(blk_max) + (CH_W+1)'(avg_a);
		result    = {alpha_sum[CH_W:1], blk_b[BLK_W-1:2], blk_g[BLK_W-1:2],
			blk_r[BLK_W-1:2]};
	end

	// Output register
	logic [PIX_W-1:0] out_data_q;
	logic             out_last_q, out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_move)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q <= result;
			out_last_q <= row_end_s1;
			out_user_q <= image_end_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

endmodule

FILE: rtl/mip_ds_checker.sv
// Port-level checks for the 2x2 mip level downsampler.
// Depends on mip_ds_pkg; bound to mipmap_2x2_downsample below.
module mip_ds_props import mip_ds_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [PIX_W-1:0] m_tdata,
	input logic             m_tlast,
	input logic             m_tuser,
	input logic             pready
);

	// a stalled output beat holds its data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// the last pixel of the image is also the last of its row
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("image end without row end");

	// input only backs up behind a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

	// no output beat while reset is held
	assert property (@(posedge clk) !arst_n |-> !m_tvalid && pready)
		else $error("output valid during reset");

endmodule

bind mipmap_2x2_downsample mip_ds_props u_mip_ds_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

FILE: sim/mip_ds_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 2x2 mip level downsampler: follows register writes and source beats,
// predicts each mip pixel and compares output beats in order. Depends on mip_ds_pkg.
module mip_ds_checker import mip_ds_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [PIX_W-1:0]  s_tdata,  // red_in, green_in, blue_in, alpha_in
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [PIX_W-1:0]  m_tdata,  // red_out, green_out, blue_out, alpha_out
	input  logic              m_tlast,  // row_end
	input  logic              m_tuser,  // image_end
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output int                fails,
	output int                pending
);

	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam logic [DIM_W-1:0] WIDTH_CAP = DIM_W'(MAX_WIDTH & ~1);
	localparam logic [DIM_W-1:0] ROWS_CAP  = DIM_W'(HEIGHT_CAP);
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic            row_end;
		logic            image_end;
	} mip_pixel_t;

	// predictor state
	logic [DIM_W-1:0]   width_reg, height_reg;
	logic [ROW_W-1:0]   src_col, src_row;
	logic [PIX_W-1:0]   held_pix;
	logic [ENTRY_W-1:0] line_sums [STORE_DEPTH];
	mip_pixel_t         mip_expected [$];

	initial fails = 0;

	task automatic report_mismatch(input string msg);
		if (fails < PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, msg);
		fails++;
	endtask

	// low bit dropped, at least 2, at most the cap
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] cap);
		logic [DIM_W-1:0] d;
		d = {v[DIM_W-1:1], 1'b0};
		if (d < DIM_W'(2)) d = DIM_W'(2);
		if (d > cap) d = cap;
		return d;
	endfunction

	// advance the predictor by one source pixel
	task automatic absorb_pixel(input logic [PIX_W-1:0] pix);
		logic [DIM_W-1:0]   w, h;
		logic [PAIR_W-1:0]  pair [4];
		logic [BLK_W-1:0]   blk [4];
		logic [CH_W-1:0]    amax, emax;
		logic [CH_W:0]      asum;
		logic [ENTRY_W-1:0] entry;
		mip_pixel_t         px;
		w = clamp_dim(width_reg, WIDTH_CAP);
		h = clamp_dim(height_reg, ROWS_CAP);
		if (!src_col[0]) begin
			held_pix = pix;
		end else begin
			for (int k = 0; k < 4; k++)
				pair[k] = PAIR_W'(held_pix[CH_W*k +: CH_W]) + PAIR_W'(pix[CH_W*k +: CH_W]);
			amax = (held_pix[PIX_W-1 -: CH_W] > pix[PIX_W-1 -: CH_W]) ?
				held_pix[PIX_W-1 -: CH_W] : pix[PIX_W-1 -: CH_W];
			if (!src_row[0]) begin
				// even row: park the pair sums for the row below
				line_sums[src_col[ROW_W-1:1]] = {amax, pair[3], pair[2], pair[1], pair[0]};
			end else begin
				entry = line_sums[src_col[ROW_W-1:1]];
				for (int k = 0; k < 4; k++)
					blk[k] = BLK_W'(pair[k]) + BLK_W'(entry[PAIR_W*k +: PAIR_W]);
				emax = entry[ENTRY_W-1 -: CH_W];
				if (emax > amax) amax = emax;
				asum = (CH_W+1)'(amax) + (CH_W+1)'(blk[3][BLK_W-1:2]);
				px.red       = blk[0][BLK_W-1:2];
				px.green     = blk[1][BLK_W-1:2];
				px.blue      = blk[2][BLK_W-1:2];
				px.alpha     = asum[CH_W:1];
				px.row_end   = (DIM_W'(src_col) == w - DIM_W'(1));
				px.image_end = px.row_end && (DIM_W'(src_row) == h - DIM_W'(1));
				mip_expected.push_back(px);
			end
		end
		// raster position, wraps at the end of the image
		if (DIM_W'(src_col) + DIM_W'(1) >= w) begin
			src_col = '0;
			src_row = (DIM_W'(src_row) + DIM_W'(1) >= h) ? '0 : src_row + 1'b1;
		end else begin
			src_col = src_col + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mip_pixel_t want;
		if (!arst_n) begin
			width_reg  = 2;
			height_reg = 2;
			src_col    = '0;
			src_row    = '0;
			held_pix   = '0;
			mip_expected.delete();
			pending <= 0;
		end else begin
			// register write: new size, counters back to the image start
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_SRC_WIDTH, 2'b00}) begin
					width_reg = pwdata[DIM_W-1:0];
					src_col = '0;
					src_row = '0;
				end else if (paddr == {REG_SRC_HEIGHT, 2'b00}) begin
					height_reg = pwdata[DIM_W-1:0];
					src_col = '0;
					src_row = '0;
				end
			end
			if (s_tvalid && s_tready)
				absorb_pixel(s_tdata);
			if (m_tvalid && m_tready) begin
				if (mip_expected.size() == 0) begin
					report_mismatch($sformatf("output beat %h with nothing expected", m_tdata));
				end else begin
					want = mip_expected.pop_front();
					if (m_tdata[CH_W*0 +: CH_W] !== want.red)
						report_mismatch($sformatf("red got %0d expected %0d",
							m_tdata[CH_W*0 +: CH_W], want.red));
					if (m_tdata[CH_W*1 +: CH_W] !== want.green)
						report_mismatch($sformatf("green got %0d expected %0d",
							m_tdata[CH_W*1 +: CH_W], want.green));
					if (m_tdata[CH_W*2 +: CH_W] !== want.blue)
						report_mismatch($sformatf("blue got %0d expected %0d",
							m_tdata[CH_W*2 +: CH_W], want.blue));
					if (m_tdata[CH_W*3 +: CH_W] !== want.alpha)
						report_mismatch($sformatf("alpha got %0d expected %0d",
							m_tdata[CH_W*3 +: CH_W], want.alpha));
					if (m_tlast !== want.row_end)
						report_mismatch($sformatf("row_end got %b expected %b",
							m_tlast, want.row_end));
					if (m_tuser !== want.image_end)
						report_mismatch($sformatf("image_end got %b expected %b",
							m_tuser, want.image_end));
				end
			end
			pending <= mip_expected.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the mip downsampler testbench: clock, reset, APB size writes, source pixels and
// output back-pressure. Depends on mip_ds_pkg, the block and mip_ds_checker.
module testbench;
	import mip_ds_pkg::*;

	localparam int MAX_WIDTH      = 4096;
	localparam int IDLE_LIMIT     = 2000;
	localparam int SQUEEZE_CYCLES = 300;
	localparam int DRAIN_PAD      = 4;
	localparam int RANDOM_PIXELS  = 1500;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid, s_tready;
	logic [PIX_W-1:0]  s_tdata;
	logic              m_tvalid, m_tready;
	logic [PIX_W-1:0]  m_tdata;
	logic              m_tlast, m_tuser;
	logic              psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	int                fails, pending;
	logic              steady, squeeze;

	mipmap_2x2_downsample #(.MAX_WIDTH(MAX_WIDTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mip_ds_checker #(.MAX_WIDTH(MAX_WIDTH)) check_mip (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// output side: random stalls, one long hold when squeeze is raised
	initial begin : sink
		bit held;
		held = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze && !held && arst_n) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	// ends the run when no beat moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// one source beat, with random idle cycles ahead of it
	task automatic put_pixel(input logic [PIX_W-1:0] pix);
		while (!steady && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering, wait for every expected pixel, then let the pipeline settle
	task automatic go_quiet();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// junk in the upper bits must be ignored by the 13-bit registers
	task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		go_quiet();
		apb_write(REG_SRC_WIDTH, {(APB_DW-DIM_W)'($urandom()), w});
		apb_write(REG_SRC_HEIGHT, {(APB_DW-DIM_W)'($urandom()), h});
	endtask

	initial begin : stimulus
		int sent, phase, count, wd, hd;
		logic [DIM_W-1:0] wreg, hreg;
		arst_n  = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		steady  = 1'b0;
		squeeze = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 2x2: full white, then full black after the image wraps
		repeat (4) put_pixel('1);
		repeat (4) put_pixel('0);
		// one opaque sample among clear ones: the maximum lifts the alpha
		put_pixel(32'hFF00_00FF);
		put_pixel(32'h0000_FF00);
		put_pixel(32'h0000_00FF);
		put_pixel(32'h00FF_0000);
		// odd and tiny sizes all fold to 2x2
		set_size(3, 1);
		put_pixel(32'h00FF_00FF);
		put_pixel(32'hFF00_FF00);
		put_pixel(32'hFF00_FF00);
		put_pixel(32'h00FF_00FF);
		set_size(0, 0);
		repeat (4) put_pixel($urandom());
		set_size(1, 2);
		repeat (4) put_pixel($urandom());

		// oversize width: the start of the first row
		set_size('1, 2);
		repeat (16) put_pixel($urandom());
		// oversize height: the first rows of a narrow image
		set_size(2, '1);
		repeat (16) put_pixel($urandom());

		// random images, some cut short, some run on without a size write
		sent = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			if (phase <= 1) begin
				wreg = 64;
				hreg = 8;
			end else begin
				wreg = DIM_W'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 300 : 40));
				hreg = DIM_W'($urandom_range(0, 10));
			end
			wd = (wreg < 2) ? 2 : (int'(wreg) & ~1);
			hd = (hreg < 2) ? 2 : (int'(hreg) & ~1);
			if (phase <= 1 || $urandom_range(0, 4) != 0)
				set_size(wreg, hreg);
			if (phase <= 1)
				count = wd * hd;
			else if ($urandom_range(0, 9) < 7)
				count = wd * hd * $urandom_range(1, 2);
			else
				count = $urandom_range(1, wd * hd - 1);
			if (count > RANDOM_PIXELS - sent)
				count = RANDOM_PIXELS - sent;
			squeeze <= (phase == 0);
			steady  <= (phase == 1);
			repeat (count) put_pixel($urandom());
			sent += count;
			phase++;
		end

		go_quiet();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
